@@ rtl/core/pbra_pkg.sv @@
// ----------------------------------------------------------------------------
// pbra_pkg
// Shared types, codes and widths of the phase-binned running averager.
// ----------------------------------------------------------------------------
`default_nettype none

package pbra_pkg;

  // Default number of phase bins.
  localparam int NUM_PHASES_DEF = 16;

  // Field widths.
  localparam int REQ_W    = 2;
  localparam int PHASE_W  = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 16;
  localparam int CYCLES_W = 32;

  // Divider widths: |avg*n + s| stays at or below 2^47, so 48 magnitude bits.
  localparam int DIVIDEND_W = 49;
  localparam int MAG_W      = 48;
  localparam int DIVISOR_W  = COUNT_W + 1;

  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [CYCLES_W-1:0] CYCLES_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_END    = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE  = 3'd0,
    ST_AVG   = 3'd1,
    ST_CUR   = 3'd2,
    ST_BLEND = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_ADD,
    S_DIVGO,
    S_DIV
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/pbra_div.sv @@
// ----------------------------------------------------------------------------
// pbra_div
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating
// toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pbra_div (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [pbra_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic        [pbra_pkg::DIVISOR_W-1:0]  divisor,
  output logic                                       done,
  output logic signed      [pbra_pkg::VALUE_W-1:0]    quotient
);

  localparam int MAG_W  = pbra_pkg::MAG_W;
  localparam int DVS_W  = pbra_pkg::DIVISOR_W;
  localparam int Q_W    = pbra_pkg::VALUE_W;
  localparam int STEP_W = $clog2(MAG_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

  logic                           running;
  logic [STEP_W-1:0]              step;
  logic [MAG_W-1:0]               shreg;
  logic [DVS_W-1:0]               rem;
  logic [DVS_W-1:0]               dvs;
  logic                           neg;

  logic signed [pbra_pkg::DIVIDEND_W-1:0] abs_full;
  logic [DVS_W:0]                 trial;
  logic [DVS_W:0]                 diff;
  logic                           fits;
  logic [Q_W-1:0]                 qmag;

  assign abs_full = dividend[pbra_pkg::DIVIDEND_W-1] ? -dividend : dividend;
  assign trial    = {rem, shreg[MAG_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = trial >= {1'b0, dvs};
  assign qmag     = shreg[Q_W-1:0];
  assign quotient = neg ? $signed(-qmag) : $signed(qmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Shift register holds the remaining dividend bits and collects quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= abs_full[MAG_W-1:0];
      rem   <= '0;
      dvs   <= divisor;
      neg   <= dividend[pbra_pkg::DIVIDEND_W-1];
    end else if (running) begin
      shreg <= {shreg[MAG_W-2:0], fits};
      rem   <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/phase_binned_running_average.sv @@
// ----------------------------------------------------------------------------
// phase_binned_running_average
// Phase-resolved ensemble averager of one signed Q16.16 value over phase bins.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Sample, clear and
// out-of-range requests leave busy low, so they may come in every cycle. A
// read goes through FETCH and EVAL, and when it blends the mean with the held
// sample also through ADD, DIVGO and DIV, since the blend goes through the
// shared serial divider (48 steps). End of cycle walks all bins: FETCH and
// EVAL for each bin, plus ADD, DIVGO and DIV for each sampled bin that already
// has a mean. The per-bin tables are memories with one registered read; their
// contents are qualified by per-bin flags that reset clears, so there is no
// clearing pass after reset. Results appear for exactly one cycle with
// result_valid and cannot be held off by the receiver.
`default_nettype none

module phase_binned_running_average #(
  parameter int NUM_PHASES = pbra_pkg::NUM_PHASES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic        [pbra_pkg::REQ_W-1:0]   req_type,
  input  wire logic        [pbra_pkg::PHASE_W-1:0] phase_index,
  input  wire logic signed [pbra_pkg::VALUE_W-1:0] sample_value,
  output logic                                     busy,
  output logic                                     result_valid,
  output logic signed      [pbra_pkg::VALUE_W-1:0]  estimate,
  output logic             [pbra_pkg::STATUS_W-1:0] status,
  output logic             [pbra_pkg::COUNT_W-1:0]  bin_count,
  output logic             [pbra_pkg::CYCLES_W-1:0] cycle_total
);

  localparam int VALUE_W = pbra_pkg::VALUE_W;
  localparam int COUNT_W = pbra_pkg::COUNT_W;
  localparam int PH_W    = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
  localparam logic [pbra_pkg::PHASE_W:0] PH_LIMIT = (pbra_pkg::PHASE_W + 1)'(NUM_PHASES);
  localparam logic [PH_W-1:0] LAST_PH = PH_W'(NUM_PHASES - 1);

  pbra_pkg::state_t state, state_next;
  pbra_pkg::req_t   req;

  logic [PH_W-1:0]              ph_in;
  logic                         in_range;
  logic [PH_W-1:0]              cur_ph;
  logic                         scan_mode;
  logic [pbra_pkg::CYCLES_W-1:0] cycles_done;
  logic [NUM_PHASES-1:0]        held_flag;
  logic [NUM_PHASES-1:0]        bin_seen;

  logic signed [VALUE_W-1:0]    avg_mem  [NUM_PHASES];
  logic        [COUNT_W-1:0]    cnt_mem  [NUM_PHASES];
  logic signed [VALUE_W-1:0]    held_mem [NUM_PHASES];
  logic signed [VALUE_W-1:0]    avg_rd;
  logic        [COUNT_W-1:0]    cnt_rd;
  logic signed [VALUE_W-1:0]    held_rd;

  logic signed [pbra_pkg::DIVIDEND_W-1:0] product;
  logic signed [pbra_pkg::DIVIDEND_W-1:0] sum;
  logic        [pbra_pkg::DIVISOR_W-1:0]  div_n;

  logic                         cur_flag;
  logic                         cur_seen;
  logic                         cnt_sat;
  logic [COUNT_W-1:0]           cnt_inc;
  logic [COUNT_W-1:0]           mult_factor;
  logic [pbra_pkg::DIVISOR_W-1:0] div_n_next;

  logic                         held_we;
  logic                         bin_we;
  logic signed [VALUE_W-1:0]    bin_avg_wdata;
  logic [COUNT_W-1:0]           bin_cnt_wdata;
  logic                         advance;
  logic                         end_accept;
  logic                         clear_accept;
  logic                         emit;
  logic signed [VALUE_W-1:0]    emit_est;
  pbra_pkg::status_t            emit_status;
  logic [COUNT_W-1:0]           emit_count;

  logic                         div_start;
  logic                         div_done;
  logic signed [VALUE_W-1:0]    div_q;

  assign req      = pbra_pkg::req_t'(req_type);
  assign ph_in    = phase_index[PH_W-1:0];
  assign in_range = {1'b0, phase_index} < PH_LIMIT;
  assign busy     = (state != pbra_pkg::S_IDLE);
  assign cur_flag = held_flag[cur_ph];
  assign cur_seen = bin_seen[cur_ph];

  // In the end-of-cycle scan a saturated count keeps n at its maximum, so the old weight is n-1.
  assign cnt_sat     = (cnt_rd == pbra_pkg::COUNT_MAX);
  assign cnt_inc     = cnt_sat ? cnt_rd : cnt_rd + 1'b1;
  assign mult_factor = (scan_mode && cnt_sat) ? cnt_rd - 1'b1 : cnt_rd;
  assign div_n_next  = (scan_mode && cnt_sat) ? {1'b0, cnt_rd}
                                              : {1'b0, cnt_rd} + 1'b1;

  pbra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (div_n),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbra_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    held_we       = 1'b0;
    bin_we        = 1'b0;
    bin_avg_wdata = held_rd;
    bin_cnt_wdata = cnt_inc;
    advance       = 1'b0;
    end_accept    = 1'b0;
    clear_accept  = 1'b0;
    emit          = 1'b0;
    emit_est      = '0;
    emit_status   = pbra_pkg::ST_NONE;
    emit_count    = '0;
    div_start     = 1'b0;
    case (state)
      pbra_pkg::S_IDLE: begin
        if (start) begin
          case (req)
            pbra_pkg::REQ_SAMPLE: begin
              if (!in_range) begin
                emit        = 1'b1;
                emit_status = pbra_pkg::ST_RANGE;
              end else if (!held_flag[ph_in]) begin
                held_we = 1'b1;
              end
            end
            pbra_pkg::REQ_END: begin
              end_accept = 1'b1;
              state_next = pbra_pkg::S_FETCH;
            end
            pbra_pkg::REQ_READ: begin
              if (!in_range) begin
                emit        = 1'b1;
                emit_status = pbra_pkg::ST_RANGE;
              end else begin
                state_next = pbra_pkg::S_FETCH;
              end
            end
            pbra_pkg::REQ_CLEAR: begin
              clear_accept = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      pbra_pkg::S_FETCH: begin
        state_next = pbra_pkg::S_EVAL;
      end
      pbra_pkg::S_EVAL: begin
        if (cur_flag && cur_seen) begin
          state_next = pbra_pkg::S_ADD;
        end else if (!scan_mode) begin
          emit       = 1'b1;
          state_next = pbra_pkg::S_IDLE;
          if (cur_seen) begin
            emit_est    = avg_rd;
            emit_status = pbra_pkg::ST_AVG;
            emit_count  = cnt_rd;
          end else if (cur_flag) begin
            emit_est    = held_rd;
            emit_status = pbra_pkg::ST_CUR;
          end
        end else begin
          // The first finalized sample of a bin becomes its mean as is.
          if (cur_flag) begin
            bin_we        = 1'b1;
            bin_avg_wdata = held_rd;
            bin_cnt_wdata = COUNT_W'(1);
          end
          advance = 1'b1;
        end
      end
      pbra_pkg::S_ADD: begin
        state_next = pbra_pkg::S_DIVGO;
      end
      pbra_pkg::S_DIVGO: begin
        div_start  = 1'b1;
        state_next = pbra_pkg::S_DIV;
      end
      pbra_pkg::S_DIV: begin
        if (div_done) begin
          if (!scan_mode) begin
            emit        = 1'b1;
            emit_est    = div_q;
            emit_status = pbra_pkg::ST_BLEND;
            emit_count  = cnt_rd;
            state_next  = pbra_pkg::S_IDLE;
          end else begin
            bin_we        = 1'b1;
            bin_avg_wdata = div_q;
            bin_cnt_wdata = cnt_inc;
            advance       = 1'b1;
          end
        end
      end
      default: begin
        state_next = pbra_pkg::S_IDLE;
      end
    endcase
    if (advance) begin
      state_next = (cur_ph == LAST_PH) ? pbra_pkg::S_IDLE : pbra_pkg::S_FETCH;
    end
  end

  // Control state: bin pointer, flags and the finalized cycle count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ph      <= '0;
      scan_mode   <= 1'b0;
      cycles_done <= '0;
      held_flag   <= '0;
      bin_seen    <= '0;
    end else begin
      if (state == pbra_pkg::S_IDLE && start) begin
        cur_ph    <= end_accept ? '0 : ph_in;
        scan_mode <= end_accept;
      end else if (advance) begin
        cur_ph <= cur_ph + 1'b1;
      end
      if (end_accept && cycles_done != pbra_pkg::CYCLES_MAX) begin
        cycles_done <= cycles_done + 1'b1;
      end
      if (clear_accept) begin
        held_flag <= '0;
      end
      if (held_we) begin
        held_flag[ph_in] <= 1'b1;
      end
      if (bin_we) begin
        bin_seen[cur_ph]  <= 1'b1;
        held_flag[cur_ph] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (held_we) begin
      held_mem[ph_in] <= sample_value;
    end
    held_rd <= held_mem[cur_ph];
  end

  always_ff @(posedge clk) begin
    if (bin_we) begin
      avg_mem[cur_ph] <= bin_avg_wdata;
      cnt_mem[cur_ph] <= bin_cnt_wdata;
    end
    avg_rd <= avg_mem[cur_ph];
    cnt_rd <= cnt_mem[cur_ph];
  end

  always_ff @(posedge clk) begin
    if (state == pbra_pkg::S_EVAL) begin
      product <= avg_rd * $signed({1'b0, mult_factor});
      div_n   <= div_n_next;
    end
    if (state == pbra_pkg::S_ADD) begin
      sum <= product + pbra_pkg::DIVIDEND_W'(held_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      estimate    <= emit_est;
      status      <= emit_status;
      bin_count   <= emit_count;
      cycle_total <= cycles_done;
    end
  end

`ifndef SYNTHESIS
  // A result only follows a request taken or work under way in the previous cycle.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a request in progress");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == pbra_pkg::ST_NONE || status == pbra_pkg::ST_RANGE))
      |-> (estimate == '0 && bin_count == '0))
    else $error("no-data or range result carries a value");

  a_cycles_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (cycles_done >= $past(cycles_done)))
    else $error("cycle count went backward");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == pbra_pkg::S_DIV))
    else $error("divider finished outside its wait state");
`endif

endmodule

`default_nettype wire
